@@ rtl/core/cpu8_execute_unit_defines.svh @@
// Assertion macros used by the execute unit top level.
`ifndef CPU8_EXECUTE_UNIT_DEFINES_SVH
`define CPU8_EXECUTE_UNIT_DEFINES_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define CPU8EU_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cpu8eu assertion failed in same cycle");
// The consequent must hold in the cycle after the antecedent.
`define CPU8EU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cpu8eu assertion failed in next cycle");
`else
`define CPU8EU_ASSERT_SAME(label, clk, rstn, ante, cons)
`define CPU8EU_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/cpu8eu_pkg.sv @@
// Types, operation codes and constants of the 8-bit execute unit.
`timescale 1ns / 1ps
package cpu8eu_pkg;

    localparam int unsigned MODE_W = 6;
    localparam int unsigned DATA_W = 8;
    localparam int unsigned ADDR_W = 16;

    // Status register bit positions: N V - B D I Z C
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_U = 5;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    localparam logic [DATA_W-1:0] RESET_SP = 8'hFD;
    localparam logic [DATA_W-1:0] RESET_P  = 8'h24;

    // Operation codes in the order of the instruction list.
    typedef enum logic [MODE_W-1:0] {
        OP_LDA, OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY, OP_TAX, OP_TAY,
        OP_TSX, OP_TXA, OP_TXS, OP_TYA, OP_ADC, OP_SBC, OP_AND, OP_ORA,
        OP_EOR, OP_BIT, OP_CMP, OP_CPX, OP_CPY, OP_INC, OP_DEC, OP_INX,
        OP_INY, OP_DEX, OP_DEY, OP_ASL, OP_ASLA, OP_LSR, OP_LSRA, OP_ROL,
        OP_ROLA, OP_ROR, OP_RORA, OP_BCC, OP_BCS, OP_BEQ, OP_BNE, OP_BMI,
        OP_BPL, OP_BVC, OP_BVS, OP_JMP, OP_CLC, OP_CLD, OP_CLI, OP_CLV,
        OP_SEC, OP_SED, OP_SEI, OP_NOP
    } op_t;

    // Architectural registers.
    typedef struct packed {
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] idx_x;
        logic [DATA_W-1:0] idx_y;
        logic [DATA_W-1:0] sp;
        logic [DATA_W-1:0] status;
    } arch_state_t;

    // One result item.
    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] write_address;
        logic [DATA_W-1:0] write_data;
        logic              pc_load;
        logic [ADDR_W-1:0] pc_target;
        logic              branch_taken;
        logic [DATA_W-1:0] status_out;
    } exec_result_t;

endpackage

@@ rtl/core/cpu8eu_regs.sv @@
// Architectural register file: A, X, Y, stack pointer and status.
`timescale 1ns / 1ps
module cpu8eu_regs
    import cpu8eu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        commit,
    input  arch_state_t state_next,
    output arch_state_t state
);

    arch_state_t state_reg;

    // Registers take the new state when an item leaves the input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.acc    <= '0;
            state_reg.idx_x  <= '0;
            state_reg.idx_y  <= '0;
            state_reg.sp     <= RESET_SP;
            state_reg.status <= RESET_P;
        end else if (commit) begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

@@ rtl/core/cpu8eu_alu.sv @@
// Combinational execute logic: ALU, flag update, store, branch and jump.
`timescale 1ns / 1ps
module cpu8eu_alu
    import cpu8eu_pkg::*;
(
    input  logic [MODE_W-1:0] mode,
    input  logic [DATA_W-1:0] operand_value,
    input  logic [ADDR_W-1:0] operand_address,
    input  arch_state_t       state,
    output arch_state_t       state_next,
    output exec_result_t      result
);

    logic [DATA_W:0]   sum;
    logic [DATA_W:0]   diff;
    logic [DATA_W:0]   cmp_diff;
    logic [DATA_W-1:0] cmp_reg;
    logic [DATA_W-1:0] zn_val;
    logic [DATA_W-1:0] m;
    logic              carry;
    logic              upd_zn;
    logic              wr;
    logic              taken;
    logic              jump;
    logic [DATA_W-1:0] wdata;
    arch_state_t       nxt;

    assign m     = operand_value;
    assign carry = state.status[FLAG_C];

    // Adder for adc, and a second adder on the inverted operand for sbc.
    assign sum  = {1'b0, state.acc} + {1'b0, m} + {{DATA_W{1'b0}}, carry};
    assign diff = {1'b0, state.acc} + {1'b0, ~m} + {{DATA_W{1'b0}}, carry};

    // Compare register selection; bit 8 of the difference is the carry.
    always_comb begin
        case (op_t'(mode))
            OP_CPX:  cmp_reg = state.idx_x;
            OP_CPY:  cmp_reg = state.idx_y;
            default: cmp_reg = state.acc;
        endcase
    end
    assign cmp_diff = {1'b0, cmp_reg} + {1'b0, ~m} + {{DATA_W{1'b0}}, 1'b1};

    // Operation decode and state update.
    always_comb begin
        nxt    = state;
        upd_zn = 1'b0;
        zn_val = '0;
        wr     = 1'b0;
        wdata  = '0;
        taken  = 1'b0;
        jump   = 1'b0;
        case (op_t'(mode))
            OP_LDA: begin nxt.acc = m; upd_zn = 1'b1; zn_val = m; end
            OP_LDX: begin nxt.idx_x = m; upd_zn = 1'b1; zn_val = m; end
            OP_LDY: begin nxt.idx_y = m; upd_zn = 1'b1; zn_val = m; end
            OP_STA: begin wr = 1'b1; wdata = state.acc; end
            OP_STX: begin wr = 1'b1; wdata = state.idx_x; end
            OP_STY: begin wr = 1'b1; wdata = state.idx_y; end
            OP_TAX: begin nxt.idx_x = state.acc; upd_zn = 1'b1; zn_val = state.acc; end
            OP_TAY: begin nxt.idx_y = state.acc; upd_zn = 1'b1; zn_val = state.acc; end
            OP_TSX: begin nxt.idx_x = state.sp; upd_zn = 1'b1; zn_val = state.sp; end
            OP_TXA: begin nxt.acc = state.idx_x; upd_zn = 1'b1; zn_val = state.idx_x; end
            OP_TXS: begin nxt.sp = state.idx_x; end
            OP_TYA: begin nxt.acc = state.idx_y; upd_zn = 1'b1; zn_val = state.idx_y; end
            OP_ADC: begin
                nxt.acc = sum[DATA_W-1:0];
                nxt.status[FLAG_V] = (m[DATA_W-1] ^ sum[DATA_W-1])
                                   & (state.acc[DATA_W-1] ^ sum[DATA_W-1]);
                nxt.status[FLAG_C] = sum[DATA_W];
                upd_zn = 1'b1;
                zn_val = sum[DATA_W-1:0];
            end
            OP_SBC: begin
                nxt.acc = diff[DATA_W-1:0];
                nxt.status[FLAG_V] = (state.acc[DATA_W-1] ^ m[DATA_W-1])
                                   & (state.acc[DATA_W-1] ^ diff[DATA_W-1]);
                nxt.status[FLAG_C] = diff[DATA_W];
                upd_zn = 1'b1;
                zn_val = diff[DATA_W-1:0];
            end
            OP_AND: begin
                nxt.acc = state.acc & m; upd_zn = 1'b1; zn_val = state.acc & m;
            end
            OP_ORA: begin
                nxt.acc = state.acc | m; upd_zn = 1'b1; zn_val = state.acc | m;
            end
            OP_EOR: begin
                nxt.acc = state.acc ^ m; upd_zn = 1'b1; zn_val = state.acc ^ m;
            end
            OP_BIT: begin
                nxt.status[FLAG_Z] = ((state.acc & m) == '0);
                nxt.status[FLAG_V] = m[6];
                nxt.status[FLAG_N] = m[7];
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                nxt.status[FLAG_C] = cmp_diff[DATA_W];
                upd_zn = 1'b1;
                zn_val = cmp_diff[DATA_W-1:0];
            end
            OP_INC: begin
                wr = 1'b1; wdata = m + 8'd1; upd_zn = 1'b1; zn_val = m + 8'd1;
            end
            OP_DEC: begin
                wr = 1'b1; wdata = m - 8'd1; upd_zn = 1'b1; zn_val = m - 8'd1;
            end
            OP_INX: begin
                nxt.idx_x = state.idx_x + 8'd1; upd_zn = 1'b1;
                zn_val = state.idx_x + 8'd1;
            end
            OP_INY: begin
                nxt.idx_y = state.idx_y + 8'd1; upd_zn = 1'b1;
                zn_val = state.idx_y + 8'd1;
            end
            OP_DEX: begin
                nxt.idx_x = state.idx_x - 8'd1; upd_zn = 1'b1;
                zn_val = state.idx_x - 8'd1;
            end
            OP_DEY: begin
                nxt.idx_y = state.idx_y - 8'd1; upd_zn = 1'b1;
                zn_val = state.idx_y - 8'd1;
            end
            OP_ASL: begin
                wr = 1'b1; nxt.status[FLAG_C] = m[7];
                wdata = {m[6:0], 1'b0}; upd_zn = 1'b1; zn_val = {m[6:0], 1'b0};
            end
            OP_ASLA: begin
                nxt.status[FLAG_C] = state.acc[7];
                nxt.acc = {state.acc[6:0], 1'b0};
                upd_zn = 1'b1; zn_val = {state.acc[6:0], 1'b0};
            end
            OP_LSR: begin
                wr = 1'b1; nxt.status[FLAG_C] = m[0];
                wdata = {1'b0, m[7:1]}; upd_zn = 1'b1; zn_val = {1'b0, m[7:1]};
            end
            OP_LSRA: begin
                nxt.status[FLAG_C] = state.acc[0];
                nxt.acc = {1'b0, state.acc[7:1]};
                upd_zn = 1'b1; zn_val = {1'b0, state.acc[7:1]};
            end
            OP_ROL: begin
                wr = 1'b1; nxt.status[FLAG_C] = m[7];
                wdata = {m[6:0], carry}; upd_zn = 1'b1; zn_val = {m[6:0], carry};
            end
            OP_ROLA: begin
                nxt.status[FLAG_C] = state.acc[7];
                nxt.acc = {state.acc[6:0], carry};
                upd_zn = 1'b1; zn_val = {state.acc[6:0], carry};
            end
            OP_ROR: begin
                wr = 1'b1; nxt.status[FLAG_C] = m[0];
                wdata = {carry, m[7:1]}; upd_zn = 1'b1; zn_val = {carry, m[7:1]};
            end
            OP_RORA: begin
                nxt.status[FLAG_C] = state.acc[0];
                nxt.acc = {carry, state.acc[7:1]};
                upd_zn = 1'b1; zn_val = {carry, state.acc[7:1]};
            end
            OP_BCC: taken = !state.status[FLAG_C];
            OP_BCS: taken = state.status[FLAG_C];
            OP_BEQ: taken = state.status[FLAG_Z];
            OP_BNE: taken = !state.status[FLAG_Z];
            OP_BMI: taken = state.status[FLAG_N];
            OP_BPL: taken = !state.status[FLAG_N];
            OP_BVC: taken = !state.status[FLAG_V];
            OP_BVS: taken = state.status[FLAG_V];
            OP_JMP: jump = 1'b1;
            OP_CLC: nxt.status[FLAG_C] = 1'b0;
            OP_CLD: nxt.status[FLAG_D] = 1'b0;
            OP_CLI: nxt.status[FLAG_I] = 1'b0;
            OP_CLV: nxt.status[FLAG_V] = 1'b0;
            OP_SEC: nxt.status[FLAG_C] = 1'b1;
            OP_SED: nxt.status[FLAG_D] = 1'b1;
            OP_SEI: nxt.status[FLAG_I] = 1'b1;
            default: begin
                // No operation, including unused codes.
                nxt = state;
            end
        endcase
        if (upd_zn) begin
            nxt.status[FLAG_Z] = (zn_val == '0);
            nxt.status[FLAG_N] = zn_val[DATA_W-1];
        end
    end

    assign state_next = nxt;

    // Result item; unused address and data fields read as zero.
    always_comb begin
        result.write_enable  = wr;
        result.write_address = wr ? operand_address : '0;
        result.write_data    = wr ? wdata : '0;
        result.pc_load       = jump | taken;
        result.pc_target     = (jump | taken) ? operand_address : '0;
        result.branch_taken  = taken;
        result.status_out    = nxt.status;
    end

endmodule

@@ rtl/core/cpu8_execute_unit.sv @@
// Usage notes:
// Execute stage of an 8-bit core without decimal arithmetic. One input item
// carries an operation code on s_tuser and the operand byte and effective
// address on s_tdata; each item gives exactly one result item on m_tdata with
// the memory write request, the PC load and target, the branch flag and the
// new status byte.
// Items are accepted when s_tvalid and s_tready are both high, and results are
// taken when m_tvalid and m_tready are both high.
// An input register feeds the combinational execute logic, which loads the
// result register; m_tvalid rises once the item has passed through both
// registers, and an item waits in the input register while the receiver stalls.
// Throughput is one item per cycle while m_tready is high; the architectural
// registers are updated as an item passes from the input register to the
// result register, so the next item sees them in the following cycle.
// Reset clears A, X and Y, sets the stack pointer to 0xFD and the status to
// 0x24, and empties both registers.
// When the receiver stalls, the result is held and one further item may wait
// in the input register; s_tready falls only when both are full.
`timescale 1ns / 1ps
`include "cpu8_execute_unit_defines.svh"
module cpu8_execute_unit
    import cpu8eu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operand_value [7:0], operand_address [23:8]
    input  logic [23:0] s_tdata,
    // mode [5:0]
    input  logic [5:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // write_enable [0], write_address [16:1], write_data [24:17], pc_load [25],
    // pc_target [41:26], branch_taken [42], status_out [50:43], zero [55:51]
    output logic [55:0] m_tdata
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [MODE_W-1:0] in_mode_reg;
    logic [DATA_W-1:0] in_value_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    exec_result_t      out_res_reg;
    exec_result_t      alu_res;
    arch_state_t       state;
    arch_state_t       state_next;
    logic              advance;
    logic              in_accept;

    // An item moves on when the result register is free or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Handshake control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input and result payload registers.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_mode_reg  <= s_tuser;
            in_value_reg <= s_tdata[DATA_W-1:0];
            in_addr_reg  <= s_tdata[DATA_W+ADDR_W-1:DATA_W];
        end
        if (advance) begin
            out_res_reg <= alu_res;
        end
    end

    cpu8eu_alu u_alu (
        .mode            (in_mode_reg),
        .operand_value   (in_value_reg),
        .operand_address (in_addr_reg),
        .state           (state),
        .state_next      (state_next),
        .result          (alu_res)
    );

    cpu8eu_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .commit     (advance),
        .state_next (state_next),
        .state      (state)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0,
                       out_res_reg.status_out,
                       out_res_reg.branch_taken,
                       out_res_reg.pc_target,
                       out_res_reg.pc_load,
                       out_res_reg.write_data,
                       out_res_reg.write_address,
                       out_res_reg.write_enable};

    // A taken branch always loads the program counter.
    `CPU8EU_ASSERT_SAME(a_taken_loads, aclk, aresetn, m_tvalid && out_res_reg.branch_taken, out_res_reg.pc_load)
    // Without a write the address and data fields are zero.
    `CPU8EU_ASSERT_SAME(a_no_write_zero, aclk, aresetn, m_tvalid && !out_res_reg.write_enable, (out_res_reg.write_address == '0) && (out_res_reg.write_data == '0))
    // The input side stalls only when both stages hold items and the output is blocked.
    `CPU8EU_ASSERT_SAME(a_ready_stall, aclk, aresetn, !s_tready, in_valid_reg && out_valid_reg && !m_tready)
    // The unused status bit stays set after every committed item.
    `CPU8EU_ASSERT_NEXT(a_unused_bit, aclk, aresetn, advance, state.status[FLAG_U])

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the 8-bit execute unit with a status and register predictor.
`timescale 1ns / 1ps
module tb_top;
    import cpu8eu_pkg::*;

    // Tracks the architectural registers and checks every result item in order.
    class exec_result_checker;
        arch_state_t  regs;
        exec_result_t pending_exec_results[$];
        int unsigned  fail_count;
        int unsigned  retired_count;

        function new();
            regs.acc    = '0;
            regs.idx_x  = '0;
            regs.idx_y  = '0;
            regs.sp     = RESET_SP;
            regs.status = RESET_P;
            fail_count    = 0;
            retired_count = 0;
        endfunction

        function void update_zn(logic [DATA_W-1:0] v);
            regs.status[FLAG_Z] = (v == '0);
            regs.status[FLAG_N] = v[7];
        endfunction

        function void compare_with(logic [DATA_W-1:0] r, logic [DATA_W-1:0] m);
            regs.status[FLAG_C] = (r >= m);
            update_zn(r - m);
        endfunction

        // Executes one operation on the tracked registers and returns its result item.
        function exec_result_t execute_op(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] m,
                                          logic [ADDR_W-1:0] addr);
            exec_result_t      res;
            logic [DATA_W:0]   sum;
            logic [DATA_W-1:0] wdata;
            logic              c_in;
            logic              wr;
            logic              taken;
            logic              load;
            wr    = 1'b0;
            taken = 1'b0;
            load  = 1'b0;
            wdata = '0;
            c_in  = regs.status[FLAG_C];
            case (mode)
                OP_LDA: begin regs.acc = m; update_zn(regs.acc); end
                OP_LDX: begin regs.idx_x = m; update_zn(regs.idx_x); end
                OP_LDY: begin regs.idx_y = m; update_zn(regs.idx_y); end
                OP_STA: begin wr = 1'b1; wdata = regs.acc; end
                OP_STX: begin wr = 1'b1; wdata = regs.idx_x; end
                OP_STY: begin wr = 1'b1; wdata = regs.idx_y; end
                OP_TAX: begin regs.idx_x = regs.acc; update_zn(regs.idx_x); end
                OP_TAY: begin regs.idx_y = regs.acc; update_zn(regs.idx_y); end
                OP_TSX: begin regs.idx_x = regs.sp; update_zn(regs.idx_x); end
                OP_TXA: begin regs.acc = regs.idx_x; update_zn(regs.acc); end
                OP_TXS: begin regs.sp = regs.idx_x; end
                OP_TYA: begin regs.acc = regs.idx_y; update_zn(regs.acc); end
                OP_ADC: begin
                    sum = {1'b0, regs.acc} + {1'b0, m} + {8'b0, c_in};
                    regs.status[FLAG_V] = (m[7] ^ sum[7]) & (regs.acc[7] ^ sum[7]);
                    regs.status[FLAG_C] = sum[8];
                    regs.acc = sum[7:0];
                    update_zn(regs.acc);
                end
                OP_SBC: begin
                    // Binary subtraction; carry set means no borrow.
                    sum = {1'b0, regs.acc} + 9'h100 - {1'b0, m} - {8'b0, ~c_in};
                    regs.status[FLAG_V] = (regs.acc[7] ^ m[7]) & (regs.acc[7] ^ sum[7]);
                    regs.status[FLAG_C] = sum[8];
                    regs.acc = sum[7:0];
                    update_zn(regs.acc);
                end
                OP_AND: begin regs.acc = regs.acc & m; update_zn(regs.acc); end
                OP_ORA: begin regs.acc = regs.acc | m; update_zn(regs.acc); end
                OP_EOR: begin regs.acc = regs.acc ^ m; update_zn(regs.acc); end
                OP_BIT: begin
                    regs.status[FLAG_Z] = ((regs.acc & m) == '0);
                    regs.status[FLAG_V] = m[6];
                    regs.status[FLAG_N] = m[7];
                end
                OP_CMP: compare_with(regs.acc, m);
                OP_CPX: compare_with(regs.idx_x, m);
                OP_CPY: compare_with(regs.idx_y, m);
                OP_INC: begin wr = 1'b1; wdata = m + 8'd1; update_zn(wdata); end
                OP_DEC: begin wr = 1'b1; wdata = m - 8'd1; update_zn(wdata); end
                OP_INX: begin regs.idx_x = regs.idx_x + 8'd1; update_zn(regs.idx_x); end
                OP_INY: begin regs.idx_y = regs.idx_y + 8'd1; update_zn(regs.idx_y); end
                OP_DEX: begin regs.idx_x = regs.idx_x - 8'd1; update_zn(regs.idx_x); end
                OP_DEY: begin regs.idx_y = regs.idx_y - 8'd1; update_zn(regs.idx_y); end
                // Memory shifts take Z and N from the shifted byte.
                OP_ASL: begin
                    wr = 1'b1; regs.status[FLAG_C] = m[7];
                    wdata = {m[6:0], 1'b0}; update_zn(wdata);
                end
                OP_ASLA: begin
                    regs.status[FLAG_C] = regs.acc[7];
                    regs.acc = {regs.acc[6:0], 1'b0}; update_zn(regs.acc);
                end
                OP_LSR: begin
                    wr = 1'b1; regs.status[FLAG_C] = m[0];
                    wdata = {1'b0, m[7:1]}; update_zn(wdata);
                end
                OP_LSRA: begin
                    regs.status[FLAG_C] = regs.acc[0];
                    regs.acc = {1'b0, regs.acc[7:1]}; update_zn(regs.acc);
                end
                OP_ROL: begin
                    wr = 1'b1; regs.status[FLAG_C] = m[7];
                    wdata = {m[6:0], c_in}; update_zn(wdata);
                end
                OP_ROLA: begin
                    regs.status[FLAG_C] = regs.acc[7];
                    regs.acc = {regs.acc[6:0], c_in}; update_zn(regs.acc);
                end
                OP_ROR: begin
                    wr = 1'b1; regs.status[FLAG_C] = m[0];
                    wdata = {c_in, m[7:1]}; update_zn(wdata);
                end
                OP_RORA: begin
                    regs.status[FLAG_C] = regs.acc[0];
                    regs.acc = {c_in, regs.acc[7:1]}; update_zn(regs.acc);
                end
                OP_BCC: taken = ~regs.status[FLAG_C];
                OP_BCS: taken = regs.status[FLAG_C];
                OP_BEQ: taken = regs.status[FLAG_Z];
                OP_BNE: taken = ~regs.status[FLAG_Z];
                OP_BMI: taken = regs.status[FLAG_N];
                OP_BPL: taken = ~regs.status[FLAG_N];
                OP_BVC: taken = ~regs.status[FLAG_V];
                OP_BVS: taken = regs.status[FLAG_V];
                OP_JMP: load = 1'b1;
                OP_CLC: regs.status[FLAG_C] = 1'b0;
                OP_CLD: regs.status[FLAG_D] = 1'b0;
                OP_CLI: regs.status[FLAG_I] = 1'b0;
                OP_CLV: regs.status[FLAG_V] = 1'b0;
                OP_SEC: regs.status[FLAG_C] = 1'b1;
                OP_SED: regs.status[FLAG_D] = 1'b1;
                OP_SEI: regs.status[FLAG_I] = 1'b1;
                // No-op and every unused code leave everything alone.
                default: ;
            endcase
            load = load | taken;
            res.write_enable  = wr;
            res.write_address = wr ? addr : '0;
            res.write_data    = wr ? wdata : '0;
            res.pc_load       = load;
            res.pc_target     = load ? addr : '0;
            res.branch_taken  = taken;
            res.status_out    = regs.status;
            return res;
        endfunction

        function void note_issued(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] m,
                                  logic [ADDR_W-1:0] addr);
            pending_exec_results.push_back(execute_op(mode, m, addr));
        endfunction

        function void check_retired(logic [55:0] data);
            exec_result_t exp_r;
            exec_result_t got;
            string        bad;
            got.write_enable  = data[0];
            got.write_address = data[16:1];
            got.write_data    = data[24:17];
            got.pc_load       = data[25];
            got.pc_target     = data[41:26];
            got.branch_taken  = data[42];
            got.status_out    = data[50:43];
            retired_count++;
            if (pending_exec_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result %0d arrived with no item outstanding: %h",
                             retired_count, data);
                return;
            end
            exp_r = pending_exec_results.pop_front();
            bad = "";
            if (got.write_enable != exp_r.write_enable)   bad = {bad, " write_enable"};
            if (got.write_address != exp_r.write_address) bad = {bad, " write_address"};
            if (got.write_data != exp_r.write_data)       bad = {bad, " write_data"};
            if (got.pc_load != exp_r.pc_load)             bad = {bad, " pc_load"};
            if (got.pc_target != exp_r.pc_target)         bad = {bad, " pc_target"};
            if (got.branch_taken != exp_r.branch_taken)   bad = {bad, " branch_taken"};
            if (got.status_out != exp_r.status_out)       bad = {bad, " status_out"};
            if (data[55:51] != '0)                        bad = {bad, " padding"};
            if (bad != "") begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("result %0d mismatch in%s", retired_count, bad);
                    $display("  expected we=%0b wa=%h wd=%h ld=%0b pt=%h bt=%0b st=%h",
                             exp_r.write_enable, exp_r.write_address, exp_r.write_data,
                             exp_r.pc_load, exp_r.pc_target, exp_r.branch_taken,
                             exp_r.status_out);
                    $display("  actual   we=%0b wa=%h wd=%h ld=%0b pt=%h bt=%0b st=%h pad=%h",
                             got.write_enable, got.write_address, got.write_data,
                             got.pc_load, got.pc_target, got.branch_taken,
                             got.status_out, data[55:51]);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [5:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    exec_result_checker tracker;
    int unsigned        send_idle_pct;
    int unsigned        recv_stall_pct;

    localparam logic [DATA_W-1:0] CORNER_BYTES [5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
    localparam int unsigned       LAST_MODE = (1 << MODE_W) - 1;

    cpu8_execute_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit well beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver back-pressure, changed on the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every accepted result item goes to the checker.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_retired(m_tdata);
    end

    // Presents one item from a falling edge and returns at the falling edge after acceptance.
    task automatic send_item(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value,
                             logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {addr, value};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_issued(mode, value, addr);
        @(negedge aclk);
    endtask

    // Holds the input idle until every outstanding result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (tracker.pending_exec_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_byte();
        if ($urandom_range(3) == 0)
            return CORNER_BYTES[3'($urandom_range(4))];
        return DATA_W'($urandom_range(255));
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return ADDR_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    initial begin
        int unsigned       issued;
        logic [MODE_W-1:0] mode;
        tracker        = new();
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        send_idle_pct  = 8;
        recv_stall_pct = 53;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed sequence: loads and stores at the extremes, overflow, borrow,
        // bit test, compares, memory shifts with carry, wrap of inc and dec,
        // branches, jump, flag operations, the no-op and the last unused code.
        send_item(OP_LDA, 8'h00, 16'h0000);
        send_item(OP_LDX, 8'hFF, 16'hFFFF);
        send_item(OP_LDY, 8'h80, 16'h1234);
        send_item(OP_STA, 8'h00, 16'hFFFF);
        send_item(OP_STX, 8'hAA, 16'h0000);
        send_item(OP_STY, 8'h55, 16'h8000);
        send_item(OP_LDA, 8'h50, 16'h0000);
        send_item(OP_ADC, 8'h50, 16'h0000);
        send_item(OP_SBC, 8'hF0, 16'h0000);
        send_item(OP_BIT, 8'hC0, 16'h0000);
        send_item(OP_CMP, 8'h00, 16'h0000);
        send_item(OP_CPX, 8'hFF, 16'h0000);
        send_item(OP_CPY, 8'hFF, 16'h0000);
        send_item(OP_ASL, 8'h80, 16'h00FF);
        send_item(OP_LSR, 8'h01, 16'h0100);
        send_item(OP_SEC, 8'h00, 16'h0000);
        send_item(OP_ROL, 8'h80, 16'hFFFE);
        send_item(OP_ROR, 8'h01, 16'h0001);
        send_item(OP_INC, 8'hFF, 16'hFFFF);
        send_item(OP_DEC, 8'h00, 16'h0000);
        send_item(OP_BEQ, 8'h00, 16'hFEDC);
        send_item(OP_BNE, 8'h00, 16'h0001);
        send_item(OP_JMP, 8'hFF, 16'hFFFF);
        send_item(OP_SED, 8'h00, 16'h0000);
        send_item(OP_NOP, 8'hFF, 16'hFFFF);
        send_item(MODE_W'(LAST_MODE), 8'hFF, 16'hFFFF);
        drain_results();

        // Three random phases: light sender gaps with heavy back-pressure, the
        // reverse, then full rate. Unused codes do not count towards the total.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 8 : (phase == 1) ? 53 : 0;
            recv_stall_pct = (phase == 0) ? 53 : (phase == 1) ? 8 : 0;
            issued = 0;
            while (issued < 600) begin
                if ($urandom_range(9) == 0) begin
                    mode = MODE_W'($urandom_range(LAST_MODE, OP_NOP + 1));
                end else begin
                    mode = MODE_W'($urandom_range(OP_NOP, 0));
                    issued++;
                end
                send_item(mode, pick_byte(), pick_address());
            end
            drain_results();
        end

        repeat (10) @(posedge aclk);
        if (tracker.fail_count == 0 && tracker.pending_exec_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
